// ===== hdl/vfc_pkg.sv =====
// Shared types, constants and codes for the vent fan thermal controller.
`timescale 1ns / 1ps

package vfc_pkg;

    // History line geometry; the history index equals the lag in sample periods
    localparam int HISTORY_DEPTH = 128;
    localparam int RISE_LAG      = 30;
    localparam int FALL_LAG      = 120;

    // Taps for the two deltas; a lag past the end reads the oldest entry
    localparam int RISE_IDX = (RISE_LAG < HISTORY_DEPTH) ? RISE_LAG : HISTORY_DEPTH - 1;
    localparam int FALL_IDX = (FALL_LAG < HISTORY_DEPTH) ? FALL_LAG : HISTORY_DEPTH - 1;

    localparam int TEMP_W  = 12;
    localparam int DELTA_W = 13;
    localparam int REG_W   = 12;
    localparam int IDX_W   = 3;

    // Operation codes
    localparam logic [2:0] OP_SAMPLE   = 3'd0;
    localparam logic [2:0] OP_FAN_ON   = 3'd1;
    localparam logic [2:0] OP_FAN_OFF  = 3'd2;
    localparam logic [2:0] OP_OPEN     = 3'd3;
    localparam logic [2:0] OP_CLOSE    = 3'd4;

    // Fan event codes
    localparam logic [1:0] FAN_EV_NONE = 2'd0;
    localparam logic [1:0] FAN_EV_ON   = 2'd1;
    localparam logic [1:0] FAN_EV_OFF  = 2'd2;

    // Window event codes
    localparam logic [2:0] WIN_EV_NONE       = 3'd0;
    localparam logic [2:0] WIN_EV_OPEN_ABS   = 3'd1;
    localparam logic [2:0] WIN_EV_OPEN_RISE  = 3'd2;
    localparam logic [2:0] WIN_EV_CLOSE_ABS  = 3'd3;
    localparam logic [2:0] WIN_EV_CLOSE_FALL = 3'd4;
    localparam logic [2:0] WIN_EV_MAN_OPEN   = 3'd5;
    localparam logic [2:0] WIN_EV_MAN_CLOSE  = 3'd6;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_TARGET       = 3'd0;
    localparam logic [IDX_W-1:0] REG_OPEN_ALWAYS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_CLOSE_ALWAYS = 3'd2;
    localparam logic [IDX_W-1:0] REG_FAN_ON       = 3'd3;
    localparam logic [IDX_W-1:0] REG_FAN_OFF      = 3'd4;
    localparam logic [IDX_W-1:0] REG_DROPPING     = 3'd5;
    localparam logic [IDX_W-1:0] REG_RAPID_RISE   = 3'd6;

    // Register reset values (Fahrenheit times 16)
    localparam logic [REG_W-1:0] TARGET_RST       = 12'd1120;
    localparam logic [REG_W-1:0] OPEN_ALWAYS_RST  = 12'd1360;
    localparam logic [REG_W-1:0] CLOSE_ALWAYS_RST = 12'd1040;
    localparam logic [REG_W-1:0] FAN_ON_RST       = 12'd1280;
    localparam logic [REG_W-1:0] FAN_OFF_RST      = 12'd1200;
    localparam logic [REG_W-1:0] DROPPING_RST     = 12'd1200;
    localparam logic [REG_W-1:0] RAPID_RISE_RST   = 12'd160;

    // Threshold register file
    typedef struct packed {
        logic [REG_W-1:0] target_temp;
        logic [REG_W-1:0] open_always_temp;
        logic [REG_W-1:0] close_always_temp;
        logic [REG_W-1:0] fan_on_temp;
        logic [REG_W-1:0] fan_off_temp;
        logic [REG_W-1:0] dropping_temp;
        logic [REG_W-1:0] rapid_rise_delta;
    } cfg_t;

    // Control shared by every history cell
    typedef struct packed {
        logic shift;
        logic seed;
    } cell_ctrl_t;

    // Decision made for one request
    typedef struct packed {
        logic       fan_running;
        logic       window_is_open;
        logic [1:0] fan_event;
        logic [2:0] window_event;
    } rule_res_t;

endpackage

// ===== hdl/vfc_hist_cell.sv =====
// One entry of the temperature history line.
`timescale 1ns / 1ps

module vfc_hist_cell
    import vfc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic signed [TEMP_W-1:0] seed_value,
    input  logic signed [TEMP_W-1:0] prev_value,
    output logic signed [TEMP_W-1:0] value
);

    logic signed [TEMP_W-1:0] value_reg;
    logic signed [TEMP_W-1:0] value_next;

    // Seed loads the first sample everywhere, shift takes the neighbor's entry
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.seed)
        begin
            value_next = seed_value;
        end
        else if (ctrl.shift)
        begin
            value_next = prev_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== hdl/vfc_rules.sv =====
// Fan and window rule logic with the fan and window state bits.
`timescale 1ns / 1ps

module vfc_rules
    import vfc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [2:0]                operation,
    input  logic signed [TEMP_W-1:0]  temperature,
    input  cfg_t                      cfg,
    input  logic signed [DELTA_W-1:0] rise,
    input  logic signed [DELTA_W-1:0] fall,
    output rule_res_t                 res
);

    logic fan_reg;
    logic fan_next;
    logic win_reg;
    logic win_next;
    logic [1:0] fan_ev;
    logic [2:0] win_ev;
    logic signed [DELTA_W-1:0] rapid_ext;

    assign rapid_ext = $signed({1'b0, cfg.rapid_rise_delta});

    // Rule evaluation; fan rules see the window state from before the request
    always_comb
    begin
        fan_next = fan_reg;
        win_next = win_reg;
        fan_ev   = FAN_EV_NONE;
        win_ev   = WIN_EV_NONE;
        unique case (operation)
            OP_SAMPLE:
            begin
                if (!fan_reg && win_reg && temperature >= $signed(cfg.fan_on_temp))
                begin
                    fan_next = 1'b1;
                    fan_ev   = FAN_EV_ON;
                end
                else if (fan_reg && temperature <= $signed(cfg.fan_off_temp))
                begin
                    fan_next = 1'b0;
                    fan_ev   = FAN_EV_OFF;
                end
                if (!win_reg)
                begin
                    if (temperature >= $signed(cfg.open_always_temp))
                    begin
                        win_next = 1'b1;
                        win_ev   = WIN_EV_OPEN_ABS;
                    end
                    else if (temperature >= $signed(cfg.target_temp) && rise > rapid_ext)
                    begin
                        win_next = 1'b1;
                        win_ev   = WIN_EV_OPEN_RISE;
                    end
                end
                else
                begin
                    if (temperature < $signed(cfg.close_always_temp))
                    begin
                        win_next = 1'b0;
                        win_ev   = WIN_EV_CLOSE_ABS;
                    end
                    else if (temperature < $signed(cfg.dropping_temp) && fall < 0)
                    begin
                        win_next = 1'b0;
                        win_ev   = WIN_EV_CLOSE_FALL;
                    end
                end
            end
            OP_FAN_ON:
            begin
                fan_next = 1'b1;
                fan_ev   = fan_reg ? FAN_EV_NONE : FAN_EV_ON;
            end
            OP_FAN_OFF:
            begin
                fan_next = 1'b0;
                fan_ev   = fan_reg ? FAN_EV_OFF : FAN_EV_NONE;
            end
            OP_OPEN:
            begin
                win_next = 1'b1;
                win_ev   = WIN_EV_MAN_OPEN;
            end
            OP_CLOSE:
            begin
                win_next = 1'b0;
                win_ev   = WIN_EV_MAN_CLOSE;
            end
            default:
            begin
                // unused codes leave everything as it is
                fan_next = fan_reg;
            end
        endcase
    end

    // State bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_reg <= 1'b0;
            win_reg <= 1'b0;
        end
        else if (accept)
        begin
            fan_reg <= fan_next;
            win_reg <= win_next;
        end
    end

    assign res.fan_running    = fan_next;
    assign res.window_is_open = win_next;
    assign res.fan_event      = fan_ev;
    assign res.window_event   = win_ev;

endmodule

// ===== hdl/vent_fan_thermal_controller_top.sv =====
// Top level of the vent fan thermal controller: history chain, registers, output stage.
`timescale 1ns / 1ps

// Takes one request per clock: a temperature sample or a manual fan/window
// command. Each request yields exactly one result, registered, in the cycle after
// acceptance; a new request is accepted every cycle unless a finished result is
// held in the output register under stall. Samples shift through a chain of
// HISTORY_DEPTH cells (first sample after reset loads all cells), and the two
// deltas come from fixed taps of that chain at the rise and fall lags. Threshold
// registers must be written via cfg while idle; the block does not enforce it.

module vent_fan_thermal_controller_top
    import vfc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [2:0]                operation,
    input  logic signed [TEMP_W-1:0]  temperature,
    // result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      fan_running,
    output logic                      window_is_open,
    output logic [1:0]                fan_event,
    output logic [2:0]                window_event,
    output logic signed [DELTA_W-1:0] rise_delta,
    output logic signed [DELTA_W-1:0] fall_delta,
    // configuration
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [REG_W-1:0]          cfg_data
);

    logic accept;
    logic is_sample;
    logic seeded_reg;
    cfg_t cfg_reg;
    cell_ctrl_t cell_ctrl;
    logic signed [TEMP_W-1:0] hist [HISTORY_DEPTH];
    logic signed [TEMP_W-1:0] head_new;
    logic signed [TEMP_W-1:0] rise_tap_new;
    logic signed [TEMP_W-1:0] fall_tap_new;
    logic signed [DELTA_W-1:0] rise_new;
    logic signed [DELTA_W-1:0] fall_new;
    rule_res_t rule_res;

    logic out_valid_reg;
    logic out_valid_next;
    rule_res_t res_reg;
    logic signed [DELTA_W-1:0] rise_reg;
    logic signed [DELTA_W-1:0] fall_reg;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign is_sample = (operation == OP_SAMPLE);

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_temp       <= TARGET_RST;
            cfg_reg.open_always_temp  <= OPEN_ALWAYS_RST;
            cfg_reg.close_always_temp <= CLOSE_ALWAYS_RST;
            cfg_reg.fan_on_temp       <= FAN_ON_RST;
            cfg_reg.fan_off_temp      <= FAN_OFF_RST;
            cfg_reg.dropping_temp     <= DROPPING_RST;
            cfg_reg.rapid_rise_delta  <= RAPID_RISE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET:       cfg_reg.target_temp       <= cfg_data;
                REG_OPEN_ALWAYS:  cfg_reg.open_always_temp  <= cfg_data;
                REG_CLOSE_ALWAYS: cfg_reg.close_always_temp <= cfg_data;
                REG_FAN_ON:       cfg_reg.fan_on_temp       <= cfg_data;
                REG_FAN_OFF:      cfg_reg.fan_off_temp      <= cfg_data;
                REG_DROPPING:     cfg_reg.dropping_temp     <= cfg_data;
                REG_RAPID_RISE:   cfg_reg.rapid_rise_delta  <= cfg_data;
                default:          cfg_reg.target_temp       <= cfg_reg.target_temp;
            endcase
        end
    end

    // Seed flag: set by the first accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= 1'b0;
        end
        else if (accept && is_sample)
        begin
            seeded_reg <= 1'b1;
        end
    end

    assign cell_ctrl.shift = accept && is_sample;
    assign cell_ctrl.seed  = accept && is_sample && !seeded_reg;

    // History chain; cell 0 takes the new sample
    for (genvar i = 0; i < HISTORY_DEPTH; i++)
    begin : g_cell
        vfc_hist_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .seed_value (temperature),
            .prev_value ((i == 0) ? temperature : hist[(i == 0) ? 0 : i - 1]),
            .value      (hist[i])
        );
    end

    // Tap values as they stand after this request; lag taps are never cell 0
    always_comb
    begin
        if (is_sample)
        begin
            head_new     = temperature;
            rise_tap_new = seeded_reg ? hist[RISE_IDX - 1] : temperature;
            fall_tap_new = seeded_reg ? hist[FALL_IDX - 1] : temperature;
        end
        else
        begin
            head_new     = hist[0];
            rise_tap_new = hist[RISE_IDX];
            fall_tap_new = hist[FALL_IDX];
        end
    end

    // A 13-bit difference of two 12-bit values always fits the delta range
    assign rise_new = DELTA_W'(head_new) - DELTA_W'(rise_tap_new);
    assign fall_new = DELTA_W'(head_new) - DELTA_W'(fall_tap_new);

    vfc_rules u_rules (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .operation   (operation),
        .temperature (temperature),
        .cfg         (cfg_reg),
        .rise        (rise_new),
        .fall        (fall_new),
        .res         (rule_res)
    );

    // Output register
    assign out_valid_next = accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg  <= rule_res;
            rise_reg <= rise_new;
            fall_reg <= fall_new;
        end
    end

    assign out_valid      = out_valid_reg;
    assign fan_running    = res_reg.fan_running;
    assign window_is_open = res_reg.window_is_open;
    assign fan_event      = res_reg.fan_event;
    assign window_event   = res_reg.window_event;
    assign rise_delta     = rise_reg;
    assign fall_delta     = fall_reg;

    // An accepted sample lands in the head cell
    a_head_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_sample |=> hist[0] == $past(temperature))
        else $error("history head does not hold the accepted sample");

    // Opening events leave the window open
    a_open_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (window_event == WIN_EV_OPEN_ABS || window_event == WIN_EV_OPEN_RISE
            || window_event == WIN_EV_MAN_OPEN) |-> window_is_open)
        else $error("window opening event with window closed");

    // Fan switch-on leaves the fan running, switch-off leaves it stopped
    a_fan_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fan_event != FAN_EV_NONE |-> fan_running == (fan_event == FAN_EV_ON))
        else $error("fan event disagrees with fan state");

    // A stalled result blocks the request side
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("request taken while result is stalled");

endmodule

// ===== tb/vfc_checker.sv =====
// Checker for the vent fan thermal controller: snoops both channels and config, predicts, compares.
`timescale 1ns / 1ps

module vfc_checker
    import vfc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [2:0]                operation,
    input  logic signed [TEMP_W-1:0]  temperature,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic                      fan_running,
    input  logic                      window_is_open,
    input  logic [1:0]                fan_event,
    input  logic [2:0]                window_event,
    input  logic signed [DELTA_W-1:0] rise_delta,
    input  logic signed [DELTA_W-1:0] fall_delta,
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [REG_W-1:0]          cfg_data,
    output int                        fail_count,
    output int                        result_count
);

    localparam int NUM_THRESH = 7;
    // history taps; a lag past the end reads the oldest entry
    localparam int RISE_TAP = (RISE_LAG < HISTORY_DEPTH) ? RISE_LAG : HISTORY_DEPTH - 1;
    localparam int FALL_TAP = (FALL_LAG < HISTORY_DEPTH) ? FALL_LAG : HISTORY_DEPTH - 1;

    typedef struct packed {
        logic                      fan;
        logic                      window;
        logic [1:0]                fan_ev;
        logic [2:0]                win_ev;
        logic signed [DELTA_W-1:0] rise;
        logic signed [DELTA_W-1:0] fall;
    } vent_status_t;

    vent_status_t             status_q[$];
    vent_status_t             want;
    logic signed [TEMP_W-1:0] temp_hist [HISTORY_DEPTH];
    logic                     hist_seeded;
    logic                     fan_is_on;
    logic                     window_open;
    logic [REG_W-1:0]         thresh [NUM_THRESH];
    int                       n_fail = 0;
    int                       n_results = 0;
    int                       bad;

    assign fail_count   = n_fail;
    assign result_count = n_results;

    // newest sample minus the one 'tap' periods back, saturated to the delta range
    function automatic logic signed [DELTA_W-1:0] hist_delta(int tap);
        int d;
        d = int'(temp_hist[0]) - int'(temp_hist[tap]);
        if (d > 4095)
            d = 4095;
        if (d < -4096)
            d = -4096;
        return d[DELTA_W-1:0];
    endfunction

    // advance the controller state by one request and return its status
    function automatic vent_status_t vent_step(logic [2:0] op, logic signed [TEMP_W-1:0] t);
        vent_status_t r;
        int           i;
        r        = '0;
        r.fan_ev = FAN_EV_NONE;
        r.win_ev = WIN_EV_NONE;
        if (op == OP_SAMPLE) begin
            if (!hist_seeded) begin
                for (i = 0; i < HISTORY_DEPTH; i++)
                    temp_hist[i] = t;
                hist_seeded = 1'b1;
            end
            else begin
                for (i = HISTORY_DEPTH - 1; i > 0; i--)
                    temp_hist[i] = temp_hist[i-1];
                temp_hist[0] = t;
            end
            r.rise = hist_delta(RISE_TAP);
            r.fall = hist_delta(FALL_TAP);
            // fan first, against the old window state
            if (!fan_is_on && window_open && t >= $signed(thresh[REG_FAN_ON])) begin
                fan_is_on = 1'b1;
                r.fan_ev  = FAN_EV_ON;
            end
            else if (fan_is_on && t <= $signed(thresh[REG_FAN_OFF])) begin
                fan_is_on = 1'b0;
                r.fan_ev  = FAN_EV_OFF;
            end
            // window
            if (!window_open) begin
                if (t >= $signed(thresh[REG_OPEN_ALWAYS])) begin
                    window_open = 1'b1;
                    r.win_ev    = WIN_EV_OPEN_ABS;
                end
                else if (t >= $signed(thresh[REG_TARGET]) &&
                         int'(r.rise) > int'(thresh[REG_RAPID_RISE])) begin
                    window_open = 1'b1;
                    r.win_ev    = WIN_EV_OPEN_RISE;
                end
            end
            else begin
                if (t < $signed(thresh[REG_CLOSE_ALWAYS])) begin
                    window_open = 1'b0;
                    r.win_ev    = WIN_EV_CLOSE_ABS;
                end
                else if (t < $signed(thresh[REG_DROPPING]) && r.fall < 0) begin
                    window_open = 1'b0;
                    r.win_ev    = WIN_EV_CLOSE_FALL;
                end
            end
        end
        else begin
            // manual commands leave the history alone
            r.rise = hist_delta(RISE_TAP);
            r.fall = hist_delta(FALL_TAP);
            case (op)
                OP_FAN_ON: begin
                    if (!fan_is_on)
                        r.fan_ev = FAN_EV_ON;
                    fan_is_on = 1'b1;
                end
                OP_FAN_OFF: begin
                    if (fan_is_on)
                        r.fan_ev = FAN_EV_OFF;
                    fan_is_on = 1'b0;
                end
                OP_OPEN: begin
                    window_open = 1'b1;
                    r.win_ev    = WIN_EV_MAN_OPEN;
                end
                OP_CLOSE: begin
                    window_open = 1'b0;
                    r.win_ev    = WIN_EV_MAN_CLOSE;
                end
                default: ;
            endcase
        end
        r.fan    = fan_is_on;
        r.window = window_open;
        return r;
    endfunction

    // one field compare; returns 1 on mismatch
    function automatic int field_diff(string name, logic [15:0] exp_v, logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, $signed(exp_v), $signed(got_v));
            return 1;
        end
        return 0;
    endfunction

    // snoop config writes, requests and results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            status_q.delete();
            for (int i = 0; i < HISTORY_DEPTH; i++)
                temp_hist[i] = '0;
            hist_seeded = 1'b0;
            fan_is_on   = 1'b0;
            window_open = 1'b0;
            thresh[REG_TARGET]       = TARGET_RST;
            thresh[REG_OPEN_ALWAYS]  = OPEN_ALWAYS_RST;
            thresh[REG_CLOSE_ALWAYS] = CLOSE_ALWAYS_RST;
            thresh[REG_FAN_ON]       = FAN_ON_RST;
            thresh[REG_FAN_OFF]      = FAN_OFF_RST;
            thresh[REG_DROPPING]     = DROPPING_RST;
            thresh[REG_RAPID_RISE]   = RAPID_RISE_RST;
        end
        else begin
            // results first: a request taken at this edge cannot have its result yet
            if (out_valid && !out_stall) begin
                n_results <= n_results + 1;
                if (status_q.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none actual fan=%0b win=%0b",
                             $time, fan_running, window_is_open);
                    n_fail <= n_fail + 1;
                end
                else begin
                    want = status_q.pop_front();
                    bad  = field_diff("fan_running", 16'(want.fan), 16'(fan_running))
                         + field_diff("window_is_open", 16'(want.window), 16'(window_is_open))
                         + field_diff("fan_event", 16'(want.fan_ev), 16'(fan_event))
                         + field_diff("window_event", 16'(want.win_ev), 16'(window_event))
                         + field_diff("rise_delta", 16'(want.rise), 16'(rise_delta))
                         + field_diff("fall_delta", 16'(want.fall), 16'(fall_delta));
                    n_fail <= n_fail + bad;
                end
            end
            if (in_valid && !in_stall)
                status_q.push_back(vent_step(operation, temperature));
            if (cfg_we && cfg_index < NUM_THRESH)
                thresh[cfg_index] = cfg_data;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the vent fan thermal controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import vfc_pkg::*;

    localparam int          WATCHDOG_LIMIT = 400;
    localparam int          HOLD_CYCLES    = 60;
    localparam int          DRAIN_CYCLES   = 4;
    localparam int          NUM_PHASES     = 6;
    localparam int          PHASE_ITEMS    = 90;
    localparam logic [2:0]  OP_SPARE_A     = 3'd5;
    localparam logic [2:0]  OP_SPARE_B     = 3'd6;
    localparam logic [2:0]  OP_SPARE_C     = 3'd7;

    logic                      clk            = 1'b0;
    logic                      rst_n          = 1'b0;
    logic                      in_valid       = 1'b0;
    logic                      in_stall;
    logic [2:0]                operation      = OP_SAMPLE;
    logic signed [TEMP_W-1:0]  temperature    = '0;
    logic                      out_valid;
    logic                      out_stall      = 1'b0;
    logic                      fan_running;
    logic                      window_is_open;
    logic [1:0]                fan_event;
    logic [2:0]                window_event;
    logic signed [DELTA_W-1:0] rise_delta;
    logic signed [DELTA_W-1:0] fall_delta;
    logic                      cfg_we         = 1'b0;
    logic [IDX_W-1:0]          cfg_index      = '0;
    logic [REG_W-1:0]          cfg_data       = '0;

    int   fail_count;
    int   result_count;
    int   requests_sent = 0;
    int   quiet_cycles  = 0;
    int   walk_temp     = 1150;
    int   walk_center   = 1150;
    logic idle_on       = 1'b1;
    logic burst_mode    = 1'b0;
    logic hold_req      = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    vent_fan_thermal_controller_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .temperature    (temperature),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .fan_running    (fan_running),
        .window_is_open (window_is_open),
        .fan_event      (fan_event),
        .window_event   (window_event),
        .rise_delta     (rise_delta),
        .fall_delta     (fall_delta),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    vfc_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .temperature    (temperature),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .fan_running    (fan_running),
        .window_is_open (window_is_open),
        .fan_event      (fan_event),
        .window_event   (window_event),
        .rise_delta     (rise_delta),
        .fall_delta     (fall_delta),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .result_count   (result_count)
    );

    // watchdog: cycles with no request and no result taken
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // result side: random stall before each result, one long hold on demand
    initial
    begin
        int n;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_req) begin
                n        = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                n = idle_on ? $urandom_range(0, 6) : 0;
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // offer one request after a random gap and wait until it is taken
    task automatic send_request(logic [2:0] op, int t);
        int gap;
        gap = (burst_mode || !idle_on) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        temperature <= TEMP_W'(t);
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
    endtask

    // stop offering, wait for every result, then let the pipeline settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (result_count < requests_sent)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_thresholds(logic [REG_W-1:0] target, logic [REG_W-1:0] open_abs,
                                   logic [REG_W-1:0] close_abs, logic [REG_W-1:0] fan_on,
                                   logic [REG_W-1:0] fan_off, logic [REG_W-1:0] dropping,
                                   logic [REG_W-1:0] rapid);
        write_reg(REG_TARGET, target);
        write_reg(REG_OPEN_ALWAYS, open_abs);
        write_reg(REG_CLOSE_ALWAYS, close_abs);
        write_reg(REG_FAN_ON, fan_on);
        write_reg(REG_FAN_OFF, fan_off);
        write_reg(REG_DROPPING, dropping);
        write_reg(REG_RAPID_RISE, rapid);
        cfg_we <= 1'b0;
    endtask

    // random request: mostly a temperature walk near the thresholds
    task automatic pick_request(output logic [2:0] op, output logic signed [TEMP_W-1:0] t,
                                output logic counts);
        int r;
        r      = $urandom_range(0, 99);
        op     = OP_SAMPLE;
        t      = TEMP_W'($urandom());
        counts = 1'b1;
        if (r < 3) begin
            op     = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
            counts = 1'b0;
        end
        else if (r < 15)
            op = 3'($urandom_range(OP_FAN_ON, OP_CLOSE));
        else if (r >= 25) begin
            if (r < 31)
                walk_temp += $urandom_range(150, 400);
            else
                walk_temp += $urandom_range(0, 60) - 30 + (walk_temp < walk_center ? 4 : -4);
            if (walk_temp > 2047)
                walk_temp = 2047;
            if (walk_temp < -2048)
                walk_temp = -2048;
            t = TEMP_W'(walk_temp);
        end
    endtask

    // stimulus
    initial
    begin
        logic [2:0]               op;
        logic signed [TEMP_W-1:0] t;
        logic                     counts;
        int                       base;
        int                       fan_on_lvl;
        int                       done;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: spare codes and manual commands before any sample
        send_request(OP_SPARE_A, 777);
        send_request(OP_SPARE_B, -1);
        send_request(OP_SPARE_C, 2047);
        send_request(OP_FAN_ON, 0);
        send_request(OP_FAN_ON, 0);
        send_request(OP_OPEN, 0);
        send_request(OP_FAN_OFF, 5);
        send_request(OP_CLOSE, 0);
        send_request(OP_FAN_OFF, 0);
        // seed, then rise, fan and absolute rules with reset thresholds
        send_request(OP_SAMPLE, 1000);
        send_request(OP_SAMPLE, 1200);
        send_request(OP_SAMPLE, 1300);
        send_request(OP_SAMPLE, 2047);
        send_request(OP_SAMPLE, 1200);
        send_request(OP_SAMPLE, 1000);
        send_request(OP_SAMPLE, 1400);
        send_request(OP_SAMPLE, 1350);
        send_request(OP_SAMPLE, -2048);
        send_request(OP_SAMPLE, 2047);
        send_request(OP_SAMPLE, 1100);
        send_request(OP_SAMPLE, 900);

        // random phases, each with its own thresholds
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: load_thresholds(TARGET_RST, OPEN_ALWAYS_RST, CLOSE_ALWAYS_RST,
                                   FAN_ON_RST, FAN_OFF_RST, DROPPING_RST, RAPID_RISE_RST);
                1: load_thresholds(12'h800, 12'h800, 12'h800, 12'h800, 12'h800, 12'h800,
                                   12'h000);
                2: load_thresholds(12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF,
                                   12'hFFF);
                default: begin
                    base       = $urandom_range(900, 1300);
                    fan_on_lvl = base + $urandom_range(0, 300);
                    load_thresholds(REG_W'(base), REG_W'(base + $urandom_range(100, 400)),
                                    REG_W'(base - $urandom_range(0, 250)), REG_W'(fan_on_lvl),
                                    REG_W'(fan_on_lvl - $urandom_range(0, 200)),
                                    REG_W'(base + $urandom_range(0, 300) - 100),
                                    REG_W'($urandom_range(0, 300)));
                    walk_center = base;
                end
            endcase
            idle_on = (phase != 2);
            done    = 0;
            while (done < PHASE_ITEMS) begin
                // back-pressure: hold the result side while requests keep coming
                if (phase == 3 && done == 40) begin
                    hold_req   = 1'b1;
                    burst_mode = 1'b1;
                end
                if (phase == 3 && done == 64)
                    burst_mode = 1'b0;
                pick_request(op, t, counts);
                send_request(op, int'(t));
                if (counts)
                    done++;
            end
        end

        drain_results();
        if (fail_count == 0 && result_count == requests_sent)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
